// ===== src/qfcfe_pkg.sv =====
package qfcfe_pkg;

	// Longest frame: type byte plus two 8-byte variable-length integers.
	localparam int unsigned FrameBytes = 17;
	localparam int unsigned FrameBits  = FrameBytes * 8;
	localparam int unsigned IdxW       = $clog2(FrameBytes);
	localparam int unsigned LenW       = 5;
	localparam int unsigned CmdW       = 3;
	localparam int unsigned StatusW    = 2;
	localparam int unsigned ValW       = 64;
	localparam int unsigned SpaceW     = 16;

	// Stream bus widths.
	localparam int unsigned SDataW = 2 * ValW + SpaceW;
	localparam int unsigned SUserW = CmdW + 1;
	localparam int unsigned MDataW = 16;
	localparam int unsigned MUserW = StatusW;

	// Frame kinds.
	typedef enum logic [CmdW-1:0] {
		CMD_CONN_CREDIT         = 3'd0,
		CMD_MAX_STREAM_DATA     = 3'd1,
		CMD_MAX_STREAMS         = 3'd2,
		CMD_DATA_BLOCKED        = 3'd3,
		CMD_STREAM_DATA_BLOCKED = 3'd4,
		CMD_COUNT_BLOCKED       = 3'd5
	} cmd_t;

	// Result status codes.
	typedef enum logic [StatusW-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SPACE = 2'd2
	} status_t;

	// Frame type bytes.
	localparam logic [7:0] TYPE_CONN_CREDIT         = 8'h10;
	localparam logic [7:0] TYPE_MAX_STREAM_DATA     = 8'h11;
	localparam logic [7:0] TYPE_MAX_STREAMS_BIDI    = 8'h12;
	localparam logic [7:0] TYPE_MAX_STREAMS_UNI     = 8'h13;
	localparam logic [7:0] TYPE_DATA_BLOCKED        = 8'h14;
	localparam logic [7:0] TYPE_STREAM_DATA_BLOCKED = 8'h15;
	localparam logic [7:0] TYPE_COUNT_BLOCKED_BIDI  = 8'h16;
	localparam logic [7:0] TYPE_COUNT_BLOCKED_UNI   = 8'h17;

	// Length prefix codes of a variable-length integer.
	localparam logic [1:0] VI_LEN1 = 2'd0;
	localparam logic [1:0] VI_LEN2 = 2'd1;
	localparam logic [1:0] VI_LEN4 = 2'd2;
	localparam logic [1:0] VI_LEN8 = 2'd3;

	// Encoded frame handed from the encoder to the serializer.
	typedef struct packed {
		logic                              drop;
		logic [0:FrameBytes-1][7:0]        bytes;
		logic [LenW-1:0]                   len;
		status_t                           status;
		logic [LenW-1:0]                   count;
	} frame_t;

	// Smallest length code that holds the value.
	function automatic logic [1:0] varint_code(input logic [ValW-1:0] v);
		logic [1:0] code;
		if (v[ValW-1:6] == '0) begin
			code = VI_LEN1;
		end else if (v[ValW-1:14] == '0) begin
			code = VI_LEN2;
		end else if (v[ValW-1:30] == '0) begin
			code = VI_LEN4;
		end else begin
			code = VI_LEN8;
		end
		return code;
	endfunction

	// Byte count for a length code.
	function automatic logic [3:0] varint_nbytes(input logic [1:0] code);
		logic [3:0] n;
		unique case (code)
			VI_LEN1: n = 4'd1;
			VI_LEN2: n = 4'd2;
			VI_LEN4: n = 4'd4;
			default: n = 4'd8;
		endcase
		return n;
	endfunction

	// Big-endian encoding, first byte in the top bits, zero filled below.
	function automatic logic [ValW-1:0] varint_align(input logic [ValW-1:0] v,
			input logic [1:0] code);
		logic [ValW-1:0] r;
		unique case (code)
			VI_LEN1: r = {code, v[5:0], 56'd0};
			VI_LEN2: r = {code, v[13:0], 48'd0};
			VI_LEN4: r = {code, v[29:0], 32'd0};
			default: r = {code, v[61:0]};
		endcase
		return r;
	endfunction

endpackage

// ===== src/qfcfe_enc.sv =====
module qfcfe_enc (
	input  logic [qfcfe_pkg::CmdW-1:0]   cmd,
	input  logic                         bidi,
	input  logic [qfcfe_pkg::ValW-1:0]   sid,
	input  logic [qfcfe_pkg::ValW-1:0]   limit_value,
	input  logic [qfcfe_pkg::SpaceW-1:0] buffer_space,
	output qfcfe_pkg::frame_t            frame
);

	logic                                per_stream;
	logic                                kind_drop;
	logic [7:0]                          type_byte;
	logic [1:0]                          sid_code;
	logic [1:0]                          lim_code;
	logic [3:0]                          sid_n;
	logic [3:0]                          lim_n;
	logic [qfcfe_pkg::LenW-1:0]          total;
	logic                                range_err;
	logic                                space_err;
	logic [qfcfe_pkg::ValW-1:0]          sid_al;
	logic [qfcfe_pkg::ValW-1:0]          lim_al;
	logic [qfcfe_pkg::FrameBits-1:0]     head_bits;
	logic [qfcfe_pkg::FrameBits-1:0]     lim_bits;
	logic [qfcfe_pkg::FrameBits-1:0]     frame_bits;
	qfcfe_pkg::status_t                  frame_status;

	// Type byte and kind decode; the unused kinds are dropped.
	always_comb begin
		per_stream = 1'b0;
		type_byte  = qfcfe_pkg::TYPE_CONN_CREDIT;
		kind_drop  = 1'b0;
		unique case (cmd)
			qfcfe_pkg::CMD_CONN_CREDIT: begin
				type_byte = qfcfe_pkg::TYPE_CONN_CREDIT;
			end
			qfcfe_pkg::CMD_MAX_STREAM_DATA: begin
				type_byte  = qfcfe_pkg::TYPE_MAX_STREAM_DATA;
				per_stream = 1'b1;
			end
			qfcfe_pkg::CMD_MAX_STREAMS: begin
				type_byte = bidi ? qfcfe_pkg::TYPE_MAX_STREAMS_BIDI
				                 : qfcfe_pkg::TYPE_MAX_STREAMS_UNI;
			end
			qfcfe_pkg::CMD_DATA_BLOCKED: begin
				type_byte = qfcfe_pkg::TYPE_DATA_BLOCKED;
			end
			qfcfe_pkg::CMD_STREAM_DATA_BLOCKED: begin
				type_byte  = qfcfe_pkg::TYPE_STREAM_DATA_BLOCKED;
				per_stream = 1'b1;
			end
			qfcfe_pkg::CMD_COUNT_BLOCKED: begin
				type_byte = bidi ? qfcfe_pkg::TYPE_COUNT_BLOCKED_BIDI
				                 : qfcfe_pkg::TYPE_COUNT_BLOCKED_UNI;
			end
			default: begin
				kind_drop = 1'b1;
			end
		endcase
	end

	// Field lengths and error checks.
	always_comb begin
		sid_code  = qfcfe_pkg::varint_code(sid);
		lim_code  = qfcfe_pkg::varint_code(limit_value);
		sid_n     = per_stream ? qfcfe_pkg::varint_nbytes(sid_code) : 4'd0;
		lim_n     = qfcfe_pkg::varint_nbytes(lim_code);
		total     = 5'd1 + 5'(sid_n) + 5'(lim_n);
		range_err = (limit_value[63:62] != 2'b00) ||
		            (per_stream && (sid[63:62] != 2'b00));
		space_err = buffer_space < {11'd0, total};
	end

	// Frame bytes: the limit follows the stream id, whose length sets the offset.
	always_comb begin
		sid_al    = per_stream ? qfcfe_pkg::varint_align(sid, sid_code) : '0;
		lim_al    = qfcfe_pkg::varint_align(limit_value, lim_code);
		head_bits = {type_byte, sid_al, 64'd0};
		unique case (sid_n)
			4'd0:    lim_bits = {8'd0, lim_al, 64'd0};
			4'd1:    lim_bits = {16'd0, lim_al, 56'd0};
			4'd2:    lim_bits = {24'd0, lim_al, 48'd0};
			4'd4:    lim_bits = {40'd0, lim_al, 32'd0};
			default: lim_bits = {72'd0, lim_al};
		endcase
		frame_bits = head_bits | lim_bits;
	end

	// Status, length and number of results, gathered into the frame.
	always_comb begin
		if (range_err) begin
			frame_status = qfcfe_pkg::ST_RANGE;
		end else if (space_err) begin
			frame_status = qfcfe_pkg::ST_SPACE;
		end else begin
			frame_status = qfcfe_pkg::ST_OK;
		end
		frame.drop   = kind_drop;
		frame.bytes  = frame_bits;
		frame.status = frame_status;
		frame.len    = (frame_status == qfcfe_pkg::ST_OK) ? total : '0;
		frame.count  = (frame_status == qfcfe_pkg::ST_OK) ? total : 5'd1;
	end

endmodule

// ===== src/qfcfe_ser.sv =====
module qfcfe_ser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         frame_valid,
	input  qfcfe_pkg::frame_t            frame,
	output logic                         done,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [qfcfe_pkg::MDataW-1:0] m_tdata,  // out_byte[7:0], frame_length[12:8], zero
	output logic [qfcfe_pkg::MUserW-1:0] m_tuser,  // status[1:0]
	output logic                         m_tlast
);

	logic [qfcfe_pkg::IdxW-1:0]    idx_q;
	logic                          out_valid_s2;
	logic [7:0]                    out_byte_s2;
	logic                          out_last_s2;
	qfcfe_pkg::status_t            out_status_s2;
	logic [qfcfe_pkg::LenW-1:0]    out_len_s2;
	logic                          load_ok;
	logic                          emit;
	logic                          last_res;
	logic [7:0]                    next_byte;

	// The result register takes a new transfer when empty or being drained.
	always_comb begin
		load_ok   = !out_valid_s2 || m_tready;
		emit      = frame_valid && !frame.drop && load_ok;
		last_res  = (5'(idx_q) == (frame.count - 5'd1));
		done      = frame_valid && (frame.drop || (emit && last_res));
		next_byte = (frame.status == qfcfe_pkg::ST_OK) ? frame.bytes[idx_q] : 8'd0;
	end

	// Byte index and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= last_res ? '0 : idx_q + 1'b1;
			end
			if (emit) begin
				out_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_s2   <= next_byte;
			out_last_s2   <= last_res;
			out_status_s2 <= frame.status;
			out_len_s2    <= frame.len;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {3'd0, out_len_s2, out_byte_s2};
	assign m_tuser  = out_status_s2;
	assign m_tlast  = out_last_s2;

endmodule

// ===== src/quic_flow_control_frame_encoder_unit.sv =====
// Encodes QUIC flow-control frames (the connection and stream credit updates
// and the matching blocked notices) into a byte stream, one byte per output
// transfer with tlast on the final byte and the frame length and status beside
// each byte. A request is held in an input register, encoded there in one
// pass, and its bytes leave through a registered output stage; the first byte
// passes from the input register into the output register before it is
// presented. A frame yields 2 to 17 results, an error one result, and an
// unused kind none. Results leave at one byte per cycle while the receiver
// does not stall, and the next request is taken in the cycle its
// predecessor's last byte is registered.
module quic_flow_control_frame_encoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [qfcfe_pkg::SDataW-1:0] s_tdata,  // sid[63:0], limit_value[127:64], buffer_space[143:128]
	input  logic [qfcfe_pkg::SUserW-1:0] s_tuser,  // cmd[2:0], bidi[3]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [qfcfe_pkg::MDataW-1:0] m_tdata,  // out_byte[7:0], frame_length[12:8], zero
	output logic [qfcfe_pkg::MUserW-1:0] m_tuser,  // status[1:0]
	output logic                         m_tlast
);

	logic                            req_valid_s1;
	logic [qfcfe_pkg::CmdW-1:0]      cmd_s1;
	logic                            bidi_s1;
	logic [qfcfe_pkg::ValW-1:0]      sid_s1;
	logic [qfcfe_pkg::ValW-1:0]      lim_s1;
	logic [qfcfe_pkg::SpaceW-1:0]    space_s1;
	qfcfe_pkg::frame_t               frame;
	logic                            done;
	logic                            s_accept;

	// A new request enters when the stage is empty, when its last result is registered, or when it is dropped.
	assign s_tready = !req_valid_s1 || done;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_accept) begin
			req_valid_s1 <= 1'b1;
		end else if (done) begin
			req_valid_s1 <= 1'b0;
		end
	end

	// Request payload.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1   <= s_tuser[2:0];
			bidi_s1  <= s_tuser[3];
			sid_s1   <= s_tdata[63:0];
			lim_s1   <= s_tdata[127:64];
			space_s1 <= s_tdata[143:128];
		end
	end

	qfcfe_enc u_enc (
		.cmd          (cmd_s1),
		.bidi         (bidi_s1),
		.sid          (sid_s1),
		.limit_value  (lim_s1),
		.buffer_space (space_s1),
		.frame        (frame)
	);

	qfcfe_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (req_valid_s1),
		.frame       (frame),
		.done        (done),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// ===== src/qfcfe_chk.sv =====
module qfcfe_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [qfcfe_pkg::SDataW-1:0] s_tdata,
	input logic [qfcfe_pkg::SUserW-1:0] s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [qfcfe_pkg::MDataW-1:0] m_tdata,
	input logic [qfcfe_pkg::MUserW-1:0] m_tuser,
	input logic                         m_tlast
);

	// A stalled result transfer holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

	// An error result is a single zero byte with zero length, marked last.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != qfcfe_pkg::ST_OK) |-> m_tlast && (m_tdata == '0))
		else $error("malformed error result");

	// A frame result carries a length of 2 to 17 bytes.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == qfcfe_pkg::ST_OK) |->
		(m_tdata[12:8] >= 5'd2) && (m_tdata[12:8] <= 5'd17))
		else $error("frame length out of range");

	// Within a frame, length and status stay the same from byte to byte.
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
		(m_tdata[12:8] == $past(m_tdata[12:8])) && (m_tuser == $past(m_tuser)))
		else $error("frame fields changed inside a frame");

endmodule

bind quic_flow_control_frame_encoder_unit qfcfe_chk u_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// Request kinds the block must ignore without producing output.
	localparam logic [qfcfe_pkg::CmdW-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [qfcfe_pkg::CmdW-1:0] CMD_UNUSED_HI = 3'd7;

	// Smallest value that no longer fits a variable-length integer.
	localparam logic [qfcfe_pkg::ValW-1:0] VarintCeil = 64'h4000_0000_0000_0000;
	localparam logic [qfcfe_pkg::ValW-1:0] AllOnes    = '1;

	// One expected output transfer.
	typedef struct packed {
		logic [7:0]                 data;
		logic                       last;
		qfcfe_pkg::status_t         status;
		logic [qfcfe_pkg::LenW-1:0] len;
	} frame_byte_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [qfcfe_pkg::SDataW-1:0]   s_tdata = '0;
	logic [qfcfe_pkg::SUserW-1:0]   s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [qfcfe_pkg::MDataW-1:0]   m_tdata;
	logic [qfcfe_pkg::MUserW-1:0]   m_tuser;
	logic                           m_tlast;

	frame_byte_t         frame_bytes_due[$];
	bit                  gaps_on = 1'b0;
	int unsigned         stall_left = 0;
	int unsigned         mismatches = 0;
	int unsigned         bytes_checked = 0;
	int unsigned         requests_sent = 0;
	int unsigned         frames_ok = 0;
	int unsigned         range_errors = 0;
	int unsigned         space_errors = 0;
	int unsigned         unused_kinds = 0;

	quic_flow_control_frame_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Free-running clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bytes needed by the shortest variable-length form of a value.
	function automatic int unsigned varint_bytes(input logic [qfcfe_pkg::ValW-1:0] v);
		if (v < 64)
			return 1;
		if (v < 16384)
			return 2;
		if (v < 64'h4000_0000)
			return 4;
		return 8;
	endfunction

	// Append a value big-endian with its length code in the top two bits.
	function automatic void push_varint(ref logic [7:0] fb[$],
			input logic [qfcfe_pkg::ValW-1:0] v);
		int unsigned n;
		int unsigned first;
		n = varint_bytes(v);
		first = fb.size();
		for (int unsigned i = 0; i < n; i++) begin
			fb.push_back(8'(v >> (8 * (n - 1 - i))));
		end
		fb[first][7:6] = 2'($clog2(n));
	endfunction

	function automatic void push_error(input qfcfe_pkg::status_t st);
		frame_byte_t r;
		r.data = 8'd0;
		r.last = 1'b1;
		r.status = st;
		r.len = '0;
		frame_bytes_due.push_back(r);
	endfunction

	// Works out the output transfers that one accepted request must produce.
	function automatic void encode_frame(input logic [qfcfe_pkg::CmdW-1:0] cmd,
			input logic bidi, input logic [qfcfe_pkg::ValW-1:0] sid,
			input logic [qfcfe_pkg::ValW-1:0] lim,
			input logic [qfcfe_pkg::SpaceW-1:0] space);
		logic [7:0]  fb[$];
		bit          per_stream;
		int unsigned total;
		frame_byte_t r;
		if (cmd > qfcfe_pkg::CMD_COUNT_BLOCKED) begin
			unused_kinds++;
			return;
		end
		per_stream = (cmd == qfcfe_pkg::CMD_MAX_STREAM_DATA) ||
			(cmd == qfcfe_pkg::CMD_STREAM_DATA_BLOCKED);
		// The range check wins over the space check.
		if (lim >= VarintCeil || (per_stream && sid >= VarintCeil)) begin
			range_errors++;
			push_error(qfcfe_pkg::ST_RANGE);
			return;
		end
		total = 1 + varint_bytes(lim) + (per_stream ? varint_bytes(sid) : 0);
		if (space < total) begin
			space_errors++;
			push_error(qfcfe_pkg::ST_SPACE);
			return;
		end
		case (cmd)
			qfcfe_pkg::CMD_CONN_CREDIT:
				fb.push_back(qfcfe_pkg::TYPE_CONN_CREDIT);
			qfcfe_pkg::CMD_MAX_STREAM_DATA:
				fb.push_back(qfcfe_pkg::TYPE_MAX_STREAM_DATA);
			qfcfe_pkg::CMD_MAX_STREAMS:
				fb.push_back(bidi ? qfcfe_pkg::TYPE_MAX_STREAMS_BIDI
					: qfcfe_pkg::TYPE_MAX_STREAMS_UNI);
			qfcfe_pkg::CMD_DATA_BLOCKED:
				fb.push_back(qfcfe_pkg::TYPE_DATA_BLOCKED);
			qfcfe_pkg::CMD_STREAM_DATA_BLOCKED:
				fb.push_back(qfcfe_pkg::TYPE_STREAM_DATA_BLOCKED);
			default:
				fb.push_back(bidi ? qfcfe_pkg::TYPE_COUNT_BLOCKED_BIDI
					: qfcfe_pkg::TYPE_COUNT_BLOCKED_UNI);
		endcase
		if (per_stream)
			push_varint(fb, sid);
		push_varint(fb, lim);
		frames_ok++;
		foreach (fb[k]) begin
			r.data = fb[k];
			r.last = (k == fb.size() - 1);
			r.status = qfcfe_pkg::ST_OK;
			r.len = 5'(fb.size());
			frame_bytes_due.push_back(r);
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
	endtask

	// Sends one request and records its expected output once it is accepted.
	task automatic send_request(input logic [qfcfe_pkg::CmdW-1:0] cmd, input logic bidi,
			input logic [qfcfe_pkg::ValW-1:0] sid, input logic [qfcfe_pkg::ValW-1:0] lim,
			input logic [qfcfe_pkg::SpaceW-1:0] space);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {space, lim, sid};
		s_tuser <= {bidi, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		requests_sent++;
		encode_frame(cmd, bidi, sid, lim, space);
	endtask

	// Stops offering requests and waits until every expected byte has arrived.
	task automatic drain_frames();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (frame_bytes_due.size() != 0);
	endtask

	// Receiver side: random stall bursts while gaps are on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (arst_n && gaps_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 9);
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	// Compares every output transfer with the oldest expected byte.
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_bytes_due.size() == 0) begin
				report_mismatch("transfer with nothing expected", 64'(m_tdata), 64'd0);
			end else begin
				want = frame_bytes_due.pop_front();
				bytes_checked++;
				if (m_tdata[7:0] !== want.data)
					report_mismatch("out_byte", 64'(m_tdata[7:0]), 64'(want.data));
				if (m_tlast !== want.last)
					report_mismatch("last", 64'(m_tlast), 64'(want.last));
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
				if (m_tdata[12:8] !== want.len)
					report_mismatch("frame_length", 64'(m_tdata[12:8]), 64'(want.len));
				if (m_tdata[15:13] !== 3'd0)
					report_mismatch("tdata fill", 64'(m_tdata[15:13]), 64'd0);
			end
		end
	end

	// Random value whose encoded length is spread over all four sizes, out of range too if allowed.
	function automatic logic [qfcfe_pkg::ValW-1:0] random_value(input bit allow_big);
		logic [qfcfe_pkg::ValW-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, allow_big ? 11 : 9))
			0, 1:    v = 64'(v[5:0]);
			2, 3:    v = 64'(v[13:0]);
			4, 5:    v = 64'(v[29:0]);
			6, 7, 8: v = 64'(v[61:0]);
			9:       v = v[$urandom_range(0, 61) +: 1] ? VarintCeil - 1 : 64'(v[5:0]);
			10:      v = v | VarintCeil;
			default: ;
		endcase
		return v;
	endfunction

	// Each length boundary of the variable-length integer.
	task automatic test_varint_lengths();
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'd0, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'd63, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'd64, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'd16383, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'd16384, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'h3FFF_FFFF, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'h4000_0000, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, VarintCeil - 1, 16'hFFFF);
		drain_frames();
	endtask

	// Out-of-range values, short buffers and the longest frame.
	task automatic test_range_and_space();
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, VarintCeil, 16'hFFFF);
		// Both errors at once must report the range error.
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b1, AllOnes, AllOnes, 16'd0);
		send_request(qfcfe_pkg::CMD_MAX_STREAM_DATA, 1'b0, VarintCeil, 64'd0, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_MAX_STREAM_DATA, 1'b0, VarintCeil - 1, VarintCeil - 1,
			16'd17);
		send_request(qfcfe_pkg::CMD_MAX_STREAM_DATA, 1'b0, VarintCeil - 1, VarintCeil - 1,
			16'd16);
		// A huge stream id is ignored where the frame carries none.
		send_request(qfcfe_pkg::CMD_DATA_BLOCKED, 1'b0, AllOnes, 64'd5, 16'd2);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b0, '0, 64'd1, 16'd0);
		drain_frames();
	endtask

	// Every frame kind but the connection credit, with both settings of the direction flag where it matters.
	task automatic test_frame_kinds();
		send_request(qfcfe_pkg::CMD_MAX_STREAMS, 1'b1, '0, 64'd100, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_MAX_STREAMS, 1'b0, '0, 64'd100, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_COUNT_BLOCKED, 1'b1, AllOnes, 64'd7, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_COUNT_BLOCKED, 1'b0, '0, 64'd70000, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_DATA_BLOCKED, 1'b1, '0, 64'd300, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_STREAM_DATA_BLOCKED, 1'b1, 64'd64, 64'd16384, 16'hFFFF);
		send_request(qfcfe_pkg::CMD_MAX_STREAM_DATA, 1'b0, 64'd0, 64'd0, 16'd3);
		drain_frames();
	endtask

	// Unused kinds give nothing, and the next frame must come out intact.
	task automatic test_unused_kinds();
		send_request(CMD_UNUSED_LO, 1'b1, AllOnes, AllOnes, 16'hFFFF);
		send_request(CMD_UNUSED_HI, 1'b0, 64'd1, 64'd1, 16'd0);
		send_request(qfcfe_pkg::CMD_CONN_CREDIT, 1'b1, AllOnes, 64'd7, 16'd2);
		drain_frames();
	endtask

	// Mostly well-formed frames with random content, some errors and noise.
	task automatic test_random_traffic(input int unsigned count);
		logic [qfcfe_pkg::CmdW-1:0]   cmd;
		logic [qfcfe_pkg::ValW-1:0]   sid;
		logic [qfcfe_pkg::ValW-1:0]   lim;
		logic [qfcfe_pkg::SpaceW-1:0] space;
		int unsigned                  need;
		for (int unsigned i = 0; i < count; i++) begin
			cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			sid = random_value(1'b1);
			lim = random_value(1'b1);
			need = 1 + varint_bytes(lim) + varint_bytes(sid);
			case ($urandom_range(0, 9))
				0, 1, 2: space = 16'($urandom_range(need > 3 ? need - 3 : 0, need + 1));
				3:       space = 16'($urandom);
				4:       space = 16'hFFFF;
				default: space = 16'($urandom_range(17, 65535));
			endcase
			send_request(cmd, 1'($urandom), sid, lim, space);
			// Now and then let the output run dry before the next request.
			if (i % 40 == 39)
				drain_frames();
		end
		drain_frames();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_varint_lengths();
		test_range_and_space();
		test_frame_kinds();
		test_unused_kinds();
		gaps_on = 1'b1;
		test_random_traffic(130);
		gaps_on = 1'b0;
		test_random_traffic(115);
		repeat (40) @(posedge clk);
		$display("Sent %0d requests: %0d frames, %0d range errors, %0d space errors, %0d unused.",
			requests_sent, frames_ok, range_errors, space_errors, unused_kinds);
		$display("Checked %0d output bytes, %0d mismatches.", bytes_checked, mismatches);
		if (mismatches == 0 && frame_bytes_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d bytes still expected.", frame_bytes_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
src/qfcfe_pkg.sv
src/qfcfe_enc.sv
src/qfcfe_ser.sv
src/quic_flow_control_frame_encoder_unit.sv
src/qfcfe_chk.sv
tb/sv/tb_top.sv
